// ===== rtl/core/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg
// Widths and sideband types shared by the triangle face normal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

	localparam int COORD_W    = 24;
	localparam int EDGE_W     = 25;
	localparam int PROD_W     = 50;
	localparam int CROSS_W    = 51;
	localparam int MAG_W      = 50;
	localparam int POS_W      = 6;
	localparam int NRM_W      = 31;
	localparam int SQ_W       = 62;
	localparam int SUM_W      = 64;
	localparam int ROOT_W     = 32;
	localparam int NUM_W      = 49;
	localparam int QUO_W      = 17;
	localparam int OUT_W      = 18;
	localparam int FRAC_BITS  = 16;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 17;
	// the largest normalized magnitude sits in [2^30, 2^31)
	localparam int NRM_MSB    = 30;

	localparam logic [QUO_W-1:0] FRAC_ONE = QUO_W'(65536);

	// data that rides alongside the square root
	typedef struct packed {
		logic             degen;
		logic [2:0]       neg;
		logic [NRM_W-1:0] nm_x;
		logic [NRM_W-1:0] nm_y;
		logic [NRM_W-1:0] nm_z;
	} sqrt_side_t;

	// data that rides alongside the dividers
	typedef struct packed {
		logic       degen;
		logic [2:0] neg;
	} div_side_t;

endpackage

`default_nettype wire

// ===== rtl/core/tfn_isqrt.sv =====
// ----------------------------------------------------------------------------
// tfn_isqrt
// Pipelined 64-bit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_isqrt (
	input  wire logic                       clk,
	input  wire logic [tfn_pkg::SUM_W-1:0]  rad,
	output logic      [tfn_pkg::ROOT_W-1:0] root
);
	import tfn_pkg::*;

	logic [SUM_W-1:0] num_s [SQRT_STEPS];
	logic [SUM_W-1:0] res_s [SQRT_STEPS];

	// one stage per pair of radicand bits, test bit 4^(31-k)
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		logic [SUM_W-1:0] num_in;
		logic [SUM_W-1:0] res_in;
		logic [SUM_W-1:0] trial;
		logic [SUM_W-1:0] num_nx;
		logic [SUM_W-1:0] res_nx;
		localparam logic [SUM_W-1:0] Bit = SUM_W'(1) << (2 * (SQRT_STEPS - 1 - k));

		if (k == 0) begin : g_first
			assign num_in = rad;
			assign res_in = '0;
		end else begin : g_rest
			assign num_in = num_s[k-1];
			assign res_in = res_s[k-1];
		end

		always_comb begin
			trial = res_in + Bit;
			if (num_in >= trial) begin
				num_nx = num_in - trial;
				res_nx = (res_in >> 1) + Bit;
			end else begin
				num_nx = num_in;
				res_nx = res_in >> 1;
			end
		end

		always_ff @(posedge clk) begin
			num_s[k] <= num_nx;
			res_s[k] <= res_nx;
		end
	end

	assign root = res_s[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/tfn_div.sv =====
// ----------------------------------------------------------------------------
// tfn_div
// Pipelined restoring divider, 17-bit quotient, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_div (
	input  wire logic                      clk,
	input  wire logic [tfn_pkg::NUM_W-1:0]  num,
	input  wire logic [tfn_pkg::ROOT_W-1:0] den,
	output logic      [tfn_pkg::QUO_W-1:0]  quo
);
	import tfn_pkg::*;

	logic [NUM_W-1:0]  rem_s [DIV_STEPS];
	logic [ROOT_W-1:0] den_s [DIV_STEPS];
	logic [QUO_W-1:0]  quo_s [DIV_STEPS];

	// stage k decides quotient bit DIV_STEPS-1-k
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [NUM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] den_in;
		logic [QUO_W-1:0]  quo_in;
		logic [NUM_W-1:0]  dsh;
		logic [NUM_W-1:0]  rem_nx;
		logic [QUO_W-1:0]  quo_nx;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_rest
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		always_comb begin
			dsh    = NUM_W'(den_in) << (DIV_STEPS - 1 - k);
			rem_nx = rem_in;
			quo_nx = quo_in;
			if (rem_in >= dsh) begin
				rem_nx = rem_in - dsh;
				quo_nx[DIV_STEPS-1-k] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= rem_nx;
			den_s[k] <= den_in;
			quo_s[k] <= quo_nx;
		end
	end

	assign quo = quo_s[DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/core/triangle_flat_normal_core.sv =====
// ----------------------------------------------------------------------------
// triangle_flat_normal_core
// Unit face normal of a triangle from three Q7.16 corners.
// ----------------------------------------------------------------------------
// Takes one triangle per clock: busy is always low, so a request is accepted
// at every edge where start is high. Each request gives one result, marked by
// a one-cycle done pulse; the depth is set by the 32-stage square root and the
// 17-stage dividers behind eight stages of edge, cross product, normalization
// and sum of squares. Results cannot be held off.
// A triangle whose cross product is zero gives a zero normal with degenerate.
`default_nettype none

module triangle_flat_normal_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic signed [tfn_pkg::COORD_W-1:0] a_x,
	input  wire logic signed [tfn_pkg::COORD_W-1:0] a_y,
	input  wire logic signed [tfn_pkg::COORD_W-1:0] a_z,
	input  wire logic signed [tfn_pkg::COORD_W-1:0] b_x,
	input  wire logic signed [tfn_pkg::COORD_W-1:0] b_y,
	input  wire logic signed [tfn_pkg::COORD_W-1:0] b_z,
	input  wire logic signed [tfn_pkg::COORD_W-1:0] c_x,
	input  wire logic signed [tfn_pkg::COORD_W-1:0] c_y,
	input  wire logic signed [tfn_pkg::COORD_W-1:0] c_z,
	output logic                                   done,
	output logic signed      [tfn_pkg::OUT_W-1:0]   norm_x,
	output logic signed      [tfn_pkg::OUT_W-1:0]   norm_y,
	output logic signed      [tfn_pkg::OUT_W-1:0]   norm_z,
	output logic                                   degenerate
);
	import tfn_pkg::*;

	localparam int Latency = SQRT_STEPS + DIV_STEPS + 1;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	logic signed [EDGE_W-1:0]  e1x_s1, e1y_s1, e1z_s1, e2x_s1, e2y_s1, e2z_s1;
	logic signed [PROD_W-1:0]  p_s2 [6];
	logic signed [CROSS_W-1:0] n_s3 [3];
	logic        [MAG_W-1:0]   m_s4 [3];
	logic        [MAG_W-1:0]   big_s4;
	logic        [MAG_W-1:0]   m_s5 [3];
	logic                      rsh_s5;
	logic        [POS_W-1:0]   amt_s5;
	logic        [NRM_W-1:0]   nm_s6 [3];
	logic        [NRM_W-1:0]   nm_s7 [3];
	logic        [SQ_W-1:0]    sq_s7 [3];
	logic        [NRM_W-1:0]   nm_s8 [3];
	logic        [SUM_W-1:0]   sum_s8;
	logic        [2:0]         neg_s4, neg_s5, neg_s6, neg_s7, neg_s8;
	logic                      dg_s4, dg_s5, dg_s6, dg_s7, dg_s8;

	logic [SQRT_STEPS-1:0] vsq_q;
	sqrt_side_t            sqs_q [SQRT_STEPS];
	logic [DIV_STEPS-1:0]  vdv_q;
	div_side_t             dvs_q [DIV_STEPS];

	logic [ROOT_W-1:0] len;
	logic [NUM_W-1:0]  num_x, num_y, num_z;
	logic [QUO_W-1:0]  q_x, q_y, q_z;

	logic [POS_W-1:0] pos;
	logic [MAG_W-1:0] mag [3];
	logic [MAG_W-1:0] big;

	assign busy = 1'b0;

	// valid chain through the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// stage 1: edge vectors
	always_ff @(posedge clk) begin
		e1x_s1 <= EDGE_W'(b_x) - EDGE_W'(a_x);
		e1y_s1 <= EDGE_W'(b_y) - EDGE_W'(a_y);
		e1z_s1 <= EDGE_W'(b_z) - EDGE_W'(a_z);
		e2x_s1 <= EDGE_W'(c_x) - EDGE_W'(a_x);
		e2y_s1 <= EDGE_W'(c_y) - EDGE_W'(a_y);
		e2z_s1 <= EDGE_W'(c_z) - EDGE_W'(a_z);
	end

	// stage 2: six partial products of the cross product
	always_ff @(posedge clk) begin
		p_s2[0] <= e1y_s1 * e2z_s1;
		p_s2[1] <= e1z_s1 * e2y_s1;
		p_s2[2] <= e1z_s1 * e2x_s1;
		p_s2[3] <= e1x_s1 * e2z_s1;
		p_s2[4] <= e1x_s1 * e2y_s1;
		p_s2[5] <= e1y_s1 * e2x_s1;
	end

	// stage 3: cross components
	always_ff @(posedge clk) begin
		n_s3[0] <= CROSS_W'(p_s2[0]) - CROSS_W'(p_s2[1]);
		n_s3[1] <= CROSS_W'(p_s2[2]) - CROSS_W'(p_s2[3]);
		n_s3[2] <= CROSS_W'(p_s2[4]) - CROSS_W'(p_s2[5]);
	end

	// stage 4: magnitudes, signs and largest magnitude
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = n_s3[i][CROSS_W-1] ? MAG_W'(-n_s3[i]) : MAG_W'(n_s3[i]);
		end
		big = mag[0];
		if (mag[1] > big) big = mag[1];
		if (mag[2] > big) big = mag[2];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			m_s4[i]   <= mag[i];
			neg_s4[i] <= n_s3[i][CROSS_W-1];
		end
		big_s4 <= big;
		dg_s4  <= (big == '0);
	end

	// stage 5: leading one of the largest magnitude, shift direction and amount
	always_comb begin
		pos = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (big_s4[i]) pos = POS_W'(i);
		end
	end

	always_ff @(posedge clk) begin
		m_s5   <= m_s4;
		neg_s5 <= neg_s4;
		dg_s5  <= dg_s4;
		rsh_s5 <= (pos > POS_W'(NRM_MSB));
		amt_s5 <= (pos > POS_W'(NRM_MSB)) ? pos - POS_W'(NRM_MSB) : POS_W'(NRM_MSB) - pos;
	end

	// stage 6: block normalization into [2^30, 2^31)
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			nm_s6[i] <= rsh_s5 ? NRM_W'(m_s5[i] >> amt_s5) : NRM_W'(m_s5[i] << amt_s5);
		end
		neg_s6 <= neg_s5;
		dg_s6  <= dg_s5;
	end

	// stage 7: squares
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s7[i] <= SQ_W'(nm_s6[i]) * SQ_W'(nm_s6[i]);
		end
		nm_s7  <= nm_s6;
		neg_s7 <= neg_s6;
		dg_s7  <= dg_s6;
	end

	// stage 8: sum of squares
	always_ff @(posedge clk) begin
		sum_s8 <= SUM_W'(sq_s7[0]) + SUM_W'(sq_s7[1]) + SUM_W'(sq_s7[2]);
		nm_s8  <= nm_s7;
		neg_s8 <= neg_s7;
		dg_s8  <= dg_s7;
	end

	// length of the normalized vector
	tfn_isqrt u_isqrt (
		.clk  (clk),
		.rad  (sum_s8),
		.root (len)
	);

	// sideband delay matching the square root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vsq_q <= '0;
		end else begin
			vsq_q <= {vsq_q[SQRT_STEPS-2:0], v_s8};
		end
	end

	always_ff @(posedge clk) begin
		sqs_q[0] <= '{degen: dg_s8, neg: neg_s8,
			nm_x: nm_s8[0], nm_y: nm_s8[1], nm_z: nm_s8[2]};
		for (int i = 1; i < SQRT_STEPS; i++) begin
			sqs_q[i] <= sqs_q[i-1];
		end
	end

	// rounded numerators: magnitude scaled by 2^16 plus half the length
	assign num_x = (NUM_W'(sqs_q[SQRT_STEPS-1].nm_x) << FRAC_BITS) + NUM_W'(len >> 1);
	assign num_y = (NUM_W'(sqs_q[SQRT_STEPS-1].nm_y) << FRAC_BITS) + NUM_W'(len >> 1);
	assign num_z = (NUM_W'(sqs_q[SQRT_STEPS-1].nm_z) << FRAC_BITS) + NUM_W'(len >> 1);

	tfn_div u_div_x (.clk(clk), .num(num_x), .den(len), .quo(q_x));
	tfn_div u_div_y (.clk(clk), .num(num_y), .den(len), .quo(q_y));
	tfn_div u_div_z (.clk(clk), .num(num_z), .den(len), .quo(q_z));

	// sideband delay matching the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vdv_q <= '0;
		end else begin
			vdv_q <= {vdv_q[DIV_STEPS-2:0], vsq_q[SQRT_STEPS-1]};
		end
	end

	always_ff @(posedge clk) begin
		dvs_q[0] <= '{degen: sqs_q[SQRT_STEPS-1].degen, neg: sqs_q[SQRT_STEPS-1].neg};
		for (int i = 1; i < DIV_STEPS; i++) begin
			dvs_q[i] <= dvs_q[i-1];
		end
	end

	// result register: clamp, apply sign, zero on degenerate
	function automatic logic signed [OUT_W-1:0] fmt_out(
		input logic [QUO_W-1:0] q,
		input logic             neg,
		input logic             degen
	);
		logic [QUO_W-1:0] qc;
		qc = (q > FRAC_ONE) ? FRAC_ONE : q;
		if (degen) return '0;
		return neg ? -OUT_W'(qc) : OUT_W'(qc);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vdv_q[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		norm_x     <= fmt_out(q_x, dvs_q[DIV_STEPS-1].neg[0], dvs_q[DIV_STEPS-1].degen);
		norm_y     <= fmt_out(q_y, dvs_q[DIV_STEPS-1].neg[1], dvs_q[DIV_STEPS-1].degen);
		norm_z     <= fmt_out(q_z, dvs_q[DIV_STEPS-1].neg[2], dvs_q[DIV_STEPS-1].degen);
		degenerate <= dvs_q[DIV_STEPS-1].degen;
	end

`ifndef SYNTHESIS
	// a degenerate result carries a zero normal
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> norm_x == '0 && norm_y == '0 && norm_z == '0)
		else $error("degenerate result with nonzero normal");

	// a proper triangle gives a nonzero, in-range normal
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && !degenerate |->
			(norm_x != '0 || norm_y != '0 || norm_z != '0) &&
			norm_x <= 18'sd65536 && norm_x >= -18'sd65536 &&
			norm_y <= 18'sd65536 && norm_y >= -18'sd65536 &&
			norm_z <= 18'sd65536 && norm_z >= -18'sd65536)
		else $error("normal component out of range");

	// every request leaving the front stages comes out after the fixed depth
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 |-> ##Latency done)
		else $error("result strobe out of step with pipeline");
`endif

endmodule

`default_nettype wire

// ===== verif/triangle_flat_normal_core_tb.sv =====
// ----------------------------------------------------------------------------
// triangle_flat_normal_core_tb
// Checks unit face normals of the triangle normal pipeline against a predictor.
// ----------------------------------------------------------------------------
// Directed triangles cover extreme coordinates, axis-aligned faces and
// degenerate (coincident and collinear) corners. Random triangles follow, with
// random gaps between requests. Each done pulse is compared with the oldest
// predicted normal.
`default_nettype none

module triangle_flat_normal_core_tb;
	import tfn_pkg::*;

	typedef struct {
		logic signed [OUT_W-1:0] nx;
		logic signed [OUT_W-1:0] ny;
		logic signed [OUT_W-1:0] nz;
		logic                    degen;
	} normal_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [COORD_W-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
	logic done;
	logic signed [OUT_W-1:0] norm_x, norm_y, norm_z;
	logic degenerate;

	normal_t expected_normals[$];
	int mismatches;
	longint cycle_count;

	localparam longint CYCLE_LIMIT = 400000;
	localparam int LATENCY = 58;

	triangle_flat_normal_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
		.c_x(c_x), .c_y(c_y), .c_z(c_z), .done(done),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z), .degenerate(degenerate)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// exact integer square root by digit recurrence
	function automatic longint unsigned int_sqrt(input longint unsigned val);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > val)
			bitv >>= 2;
		while (bitv != 0) begin
			if (val >= res + bitv) begin
				val -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// face normal of one triangle
	function automatic normal_t face_normal(input logic signed [COORD_W-1:0] crd[9]);
		longint e1[3], e2[3], cr[3];
		longint unsigned mg[3];
		longint unsigned peak, sum, root, q;
		normal_t r;
		int sh;
		for (int i = 0; i < 3; i++) begin
			e1[i] = longint'(crd[3+i]) - longint'(crd[i]);
			e2[i] = longint'(crd[6+i]) - longint'(crd[i]);
		end
		cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
		cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
		cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
		peak = 0;
		for (int i = 0; i < 3; i++) begin
			mg[i] = (cr[i] < 0) ? longint'(-cr[i]) : cr[i];
			if (mg[i] > peak)
				peak = mg[i];
		end
		r = '{default: 0};
		if (peak == 0) begin
			r.degen = 1'b1;
			return r;
		end
		// block normalization into [2^30, 2^31)
		sh = 0;
		if (peak >= (64'd1 << 31)) begin
			while ((peak >> sh) >= (64'd1 << 31))
				sh++;
			for (int i = 0; i < 3; i++)
				mg[i] >>= sh;
		end else begin
			while ((peak << sh) < (64'd1 << 30))
				sh++;
			for (int i = 0; i < 3; i++)
				mg[i] <<= sh;
		end
		sum = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
		root = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = (mg[i] * 65536 + (root >> 1)) / root;
			if (q > 65536)
				q = 65536;
			if (cr[i] < 0)
				q = -q;
			if (i == 0) r.nx = q[OUT_W-1:0];
			else if (i == 1) r.ny = q[OUT_W-1:0];
			else r.nz = q[OUT_W-1:0];
		end
		return r;
	endfunction

	// send one triangle request after a random gap
	task automatic send_triangle(input logic signed [COORD_W-1:0] crd[9]);
		int gap;
		gap = $urandom_range(0, 16);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		a_x <= crd[0]; a_y <= crd[1]; a_z <= crd[2];
		b_x <= crd[3]; b_y <= crd[4]; b_z <= crd[5];
		c_x <= crd[6]; c_y <= crd[7]; c_z <= crd[8];
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		expected_normals = {expected_normals, face_normal(crd)};
	endtask

	task automatic send_corners(input int ax, ay, az, bx, by, bz, cx, cy, cz);
		logic signed [COORD_W-1:0] crd[9];
		crd = '{COORD_W'(ax), COORD_W'(ay), COORD_W'(az),
			COORD_W'(bx), COORD_W'(by), COORD_W'(bz),
			COORD_W'(cx), COORD_W'(cy), COORD_W'(cz)};
		send_triangle(crd);
	endtask

	task automatic idle_until_drained();
		start <= 1'b0;
		@(posedge clk);
		while (expected_normals.size() != 0)
			@(posedge clk);
	endtask

	// extreme coordinates, unit faces and degenerate corners
	task automatic test_directed();
		int mx, mn;
		mx = 8388607;
		mn = -8388608;
		send_corners(0, 0, 0, 65536, 0, 0, 0, 65536, 0);
		send_corners(0, 0, 0, 0, 65536, 0, 65536, 0, 0);
		send_corners(0, 0, 0, 0, 0, 65536, 65536, 0, 0);
		send_corners(0, 0, 0, 0, 65536, 0, 0, 0, 65536);
		send_corners(0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_corners(5, 6, 7, 5, 6, 7, 100, 200, 300);
		send_corners(0, 0, 0, 1, 2, 3, 2, 4, 6);
		send_corners(mn, mn, mn, mx, mx, mx, mn, mx, mn);
		send_corners(mn, mn, mn, mx, mn, mn, mn, mx, mn);
		send_corners(mx, mx, mx, mn, mx, mx, mx, mn, mx);
		send_corners(mn, mx, mn, mx, mn, mx, mx, mx, mn);
		send_corners(0, 0, 0, 1, 0, 0, 0, 1, 0);
		send_corners(0, 0, 0, 1, 0, 0, 1, 1, 0);
		send_corners(mx, 0, mn, 0, mx, 0, mn, mn, mx);
		send_corners(-1, -1, -1, 0, 0, 0, 1, 0, 0);
		send_corners(0, 0, 0, 3, 4, 0, 4, -3, 0);
		send_corners(0, 0, 0, 1, 1, 1, 1, -1, 0);
		send_corners(mx, mx, mx, mn, mn, mn, 0, 0, 0);
	endtask

	// random triangles: mostly full range, some small, some degenerate
	task automatic test_random(input int count);
		logic signed [COORD_W-1:0] crd[9];
		int kind;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(0, 9);
			for (int i = 0; i < 9; i++) begin
				crd[i] = COORD_W'($urandom());
				if (kind == 7)
					crd[i] = COORD_W'($urandom_range(0, 6) - 3);
			end
			if (kind == 8) begin
				// repeated corner
				for (int i = 0; i < 3; i++)
					crd[3+i] = crd[i];
			end else if (kind == 9) begin
				// collinear: c = a + 2 * (b - a) on small edges
				for (int i = 0; i < 3; i++) begin
					crd[3+i] = crd[i] + COORD_W'($urandom_range(0, 4000)) - COORD_W'(2000);
					crd[6+i] = (crd[3+i] << 1) - crd[i];
				end
			end
			send_triangle(crd);
			if (n == count / 2)
				idle_until_drained();
		end
	endtask

	// result checker
	always @(posedge clk) begin
		normal_t exp_n;
		if (arst_n && done) begin
			if (expected_normals.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d %0d %0d %0b",
						norm_x, norm_y, norm_z, degenerate);
			end else begin
				exp_n = expected_normals.pop_front();
				if (norm_x !== exp_n.nx || norm_y !== exp_n.ny ||
						norm_z !== exp_n.nz || degenerate !== exp_n.degen) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
							exp_n.nx, exp_n.ny, exp_n.nz, exp_n.degen,
							norm_x, norm_y, norm_z, degenerate);
				end
			end
		end
	end

	// timeout
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// main sequence
	initial begin
		mismatches = 0;
		cycle_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1200);
		idle_until_drained();
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0 && expected_normals.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
